[hw/rtl/uvst_pkg.sv]
// Shared constants and types for the unique value set table.
`timescale 1ns / 1ps

package uvst_pkg;

  // Default build parameters
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 48;

  // Fixed field widths of the request and result
  localparam int MODE_W  = 2;
  localparam int KEY_W   = 48;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int TOTAL_W = 54;
  localparam int STAT_W  = 2;
  localparam int WIDE_W  = 64;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NOACT = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

  // Token handed from cell to cell along the chain
  typedef struct packed {
    logic tok;
    logic hit;
  } link_t;

endpackage

[hw/rtl/uvst_cell.sv]
// One storage cell of the set table chain: compare, shift down, append.
`timescale 1ns / 1ps

module uvst_cell #(
  parameter int VALUE_BITS = uvst_pkg::VALUE_BITS_DEF,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  uvst_pkg::link_t           link_in,
  input  logic [IDX_W-1:0]          pos_in,
  output uvst_pkg::link_t           link_out,
  output logic [IDX_W-1:0]          pos_out,
  input  logic [uvst_pkg::MODE_W-1:0] op_mode,
  input  logic [VALUE_BITS-1:0]     op_key,
  input  logic [CNT_W-1:0]          count,
  input  logic [VALUE_BITS-1:0]     next_entry,
  output logic [VALUE_BITS-1:0]     entry
);

  logic active;
  logic match;
  logic hit_now;

  // Only entries below the count take part in the compare
  assign active  = CNT_W'(INDEX) < count;
  assign match   = active && (entry == op_key);
  assign hit_now = link_in.hit | match;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.tok <= link_in.tok;
      link_out.hit <= hit_now;
    end
  end

  always_ff @(posedge clk) begin
    pos_out <= match ? IDX_W'(INDEX) : pos_in;
  end

  // Remove: the hit cell and all above it take the upper neighbor's value.
  // Add: the first free cell takes the key if no cell below held it.
  always_ff @(posedge clk) begin
    if (link_in.tok) begin
      if (op_mode == uvst_pkg::MODE_REMOVE && hit_now) begin
        entry <= next_entry;
      end else if (op_mode == uvst_pkg::MODE_ADD && !link_in.hit &&
                   count == CNT_W'(INDEX)) begin
        entry <= op_key;
      end
    end
  end

endmodule

[hw/rtl/unique_value_set_table.sv]
// Top level of the unique value set table: controller and chain of cells.
`timescale 1ns / 1ps
// Flow: an accepted request launches a token that walks the cell chain,
// one cell per cycle; the result then waits in the hold state until the
// output register is free. No new request is taken until then (in_stall).
// Reset: rst (synchronous) empties the table, clears the total and drops any
// request in flight; stored values stay undefined until written.

module unique_value_set_table #(
  parameter int CAPACITY   = uvst_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = uvst_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [uvst_pkg::MODE_W-1:0]       mode,
  input  logic signed [uvst_pkg::KEY_W-1:0] key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic [uvst_pkg::POS_W-1:0]        position,
  output logic [uvst_pkg::COUNT_W-1:0]      entry_count,
  output logic signed [uvst_pkg::TOTAL_W-1:0] total,
  output logic [uvst_pkg::STAT_W-1:0]       status
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WIDE_W = uvst_pkg::WIDE_W;
  localparam int TOT_W  = uvst_pkg::TOTAL_W;

  // Controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                  state;
  logic                        start;
  logic [uvst_pkg::MODE_W-1:0] op_mode;
  logic [VALUE_BITS-1:0]       op_key;
  logic [CNT_W-1:0]            count;
  logic [TOT_W-1:0]            sum;
  logic                        res_found;
  logic [uvst_pkg::POS_W-1:0]  res_pos;
  logic [uvst_pkg::STAT_W-1:0] res_status;

  logic [WIDE_W-1:0]           key_wide;
  logic [WIDE_W-1:0]           key_sx;
  logic [TOT_W-1:0]            delta;
  logic [WIDE_W-1:0]           pos_wide;
  logic [WIDE_W-1:0]           cnt_wide;
  logic                        slot_free;
  logic                        tail_tok;
  logic                        tail_hit;

  uvst_pkg::link_t             link [0:CAPACITY];
  logic [IDX_W-1:0]            pos  [0:CAPACITY];
  logic [VALUE_BITS-1:0]       ent  [0:CAPACITY-1];
  logic [CAPACITY:0]           tok_vec;

  // Key bits above the value width are dropped; values wider than the port
  // are zero-filled above it.
  assign key_wide = {{(WIDE_W - uvst_pkg::KEY_W){1'b0}}, key};

  // Sign-extend the stored value into the width of the total
  assign key_sx = {{(WIDE_W - VALUE_BITS){op_key[VALUE_BITS-1]}}, op_key};
  assign delta  = key_sx[TOT_W-1:0];

  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;

  // Head of the chain: the token enters cell zero with no hit yet
  assign link[0].tok = start;
  assign link[0].hit = 1'b0;
  assign pos[0]      = '0;

  assign tail_tok = link[CAPACITY].tok;
  assign tail_hit = link[CAPACITY].hit;
  assign pos_wide = {{(WIDE_W - IDX_W){1'b0}}, pos[CAPACITY]};
  assign cnt_wide = {{(WIDE_W - CNT_W){1'b0}}, count};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VALUE_BITS-1:0] upper;
      // The top cell has no upper neighbor; what it shifts in lies past
      // the count and is never read.
      if (gi == CAPACITY - 1) begin : g_top
        assign upper = ent[gi];
      end else begin : g_mid
        assign upper = ent[gi + 1];
      end

      uvst_cell #(
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .INDEX      (gi)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .link_in    (link[gi]),
        .pos_in     (pos[gi]),
        .link_out   (link[gi + 1]),
        .pos_out    (pos[gi + 1]),
        .op_mode    (op_mode),
        .op_key     (op_key),
        .count      (count),
        .next_entry (upper),
        .entry      (ent[gi])
      );
    end

    for (gi = 0; gi <= CAPACITY; gi++) begin : g_tok
      assign tok_vec[gi] = link[gi].tok;
    end
  endgenerate

  // Request capture: hold mode and key steady for the whole sweep
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_mode <= mode;
      op_key  <= key_wide[VALUE_BITS-1:0];
    end
  end

  // Controller: launch the token, settle count and total when it leaves
  // the last cell, then hand the result to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      start <= (state == ST_IDLE) && in_valid;
      // Drop a taken result unless a new one is loaded at this edge
      if (out_valid && !out_stall && state != ST_HOLD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tail_tok) begin
            state <= ST_HOLD;
            unique case (op_mode)
              uvst_pkg::MODE_ADD: begin
                if (tail_hit) begin
                  res_status <= uvst_pkg::STATUS_NOACT;
                end else if (count == CNT_W'(CAPACITY)) begin
                  res_status <= uvst_pkg::STATUS_FULL;
                end else begin
                  res_status <= uvst_pkg::STATUS_DONE;
                  count      <= count + CNT_W'(1);
                  sum        <= sum + delta;
                end
              end
              uvst_pkg::MODE_REMOVE: begin
                if (!tail_hit) begin
                  res_status <= uvst_pkg::STATUS_NOACT;
                end else begin
                  res_status <= uvst_pkg::STATUS_DONE;
                  count      <= count - CNT_W'(1);
                  sum        <= sum - delta;
                end
              end
              default: begin
                // Lookup, and the unused mode code, leave the table alone
                res_status <= uvst_pkg::STATUS_DONE;
              end
            endcase
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload: position and hit come off the end of the chain
  always_ff @(posedge clk) begin
    if (state == ST_RUN && tail_tok) begin
      res_found <= tail_hit;
      res_pos   <= pos_wide[uvst_pkg::POS_W-1:0];
    end
    if (state == ST_HOLD && slot_free) begin
      found       <= res_found;
      position    <= res_pos;
      status      <= res_status;
      entry_count <= cnt_wide[uvst_pkg::COUNT_W-1:0];
      total       <= sum;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one token in the cell chain");

  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    tail_tok |-> state == ST_RUN)
    else $error("token left the chain outside a sweep");

  a_remove_drops: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && tail_tok && tail_hit && op_mode == uvst_pkg::MODE_REMOVE)
    |=> count == $past(count) - CNT_W'(1))
    else $error("remove hit did not lower the count");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> in_stall && !start || tok_vec != '0 || start)
    else $error("sweep running with no token");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the unique value set table.
`timescale 1ns / 1ps

module testbench;
  import uvst_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_AT      = 120;   // request count that triggers the long output hold
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_ITEMS   = 40;    // final requests run with no idling at all

  localparam logic [KEY_W-1:0] KEY_MAX  = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic [KEY_W-1:0] KEY_MIN  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] KEY_ZERO = '0;
  localparam logic [KEY_W-1:0] KEY_NEG1 = '1;
  localparam logic [KEY_W-1:0] KEY_ONE  = 48'h000001000000;   // 1.0 in Q24.24
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;            // undefined selector, acts as lookup

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    bit                quiet_first;   // hold this request until every result is back
  } request_t;

  typedef struct {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] total;
    logic [STAT_W-1:0]  status;
  } set_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        mode     = '0;
  logic signed [KEY_W-1:0]  key      = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [POS_W-1:0]         position;
  logic [COUNT_W-1:0]       entry_count;
  logic signed [TOTAL_W-1:0] total;
  logic [STAT_W-1:0]        status;

  unique_value_set_table u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .position    (position),
    .entry_count (entry_count),
    .total       (total),
    .status      (status)
  );

  // Predicted table contents, kept apart from the stimulus generator
  logic [KEY_W-1:0] shadow_vals [CAP];
  int               shadow_count = 0;
  logic [WIDE_W-1:0] shadow_sum  = '0;

  request_t    pending_reqs [$];
  set_result_t expected_results [$];

  int n_sent    = 0;    // requests accepted by the block
  int n_seen    = 0;    // results taken from the block
  int n_total   = 0;    // requests queued by the generator
  int err_count = 0;

  // Apply one request to the shadow table and return the result it should give.
  function automatic set_result_t apply_request(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k);
    set_result_t r;
    int          hit_at;
    hit_at = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit_at < 0 && shadow_vals[i] == k) hit_at = i;
    r.status = STATUS_DONE;
    if (m == MODE_ADD) begin
      if (hit_at >= 0) begin
        r.status = STATUS_NOACT;
      end else if (shadow_count >= CAP) begin
        r.status = STATUS_FULL;
      end else begin
        shadow_vals[shadow_count] = k;
        shadow_count++;
        shadow_sum += {{(WIDE_W-KEY_W){k[KEY_W-1]}}, k};
      end
    end else if (m == MODE_REMOVE) begin
      if (hit_at < 0) begin
        r.status = STATUS_NOACT;
      end else begin
        shadow_sum -= {{(WIDE_W-KEY_W){k[KEY_W-1]}}, k};
        for (int i = hit_at; i + 1 < shadow_count; i++) shadow_vals[i] = shadow_vals[i+1];
        shadow_count--;
      end
    end
    r.found       = (hit_at >= 0);
    r.position    = (hit_at >= 0) ? hit_at[POS_W-1:0] : '0;
    r.entry_count = shadow_count[COUNT_W-1:0];
    r.total       = shadow_sum[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Clock: 10 ns period
  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset once, at the start
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Stimulus generation: directed requests first, then random segments
  initial begin
    logic [KEY_W-1:0] key_pool [$];
    int               seg;
    int               n;
    int               idx;
    int               directed_n;

    // Empty table: lookup, remove of an absent key, undefined selector
    push_req(MODE_LOOKUP, KEY_ZERO, 1'b0);
    push_req(MODE_REMOVE, KEY_ONE, 1'b0);
    push_req(MODE_SPARE, KEY_NEG1, 1'b0);
    // Extremes of the key, then duplicates
    push_req(MODE_ADD, KEY_MAX, 1'b0);
    push_req(MODE_ADD, KEY_MIN, 1'b0);
    push_req(MODE_ADD, KEY_ZERO, 1'b0);
    push_req(MODE_ADD, KEY_NEG1, 1'b0);
    push_req(MODE_ADD, KEY_MAX, 1'b0);
    push_req(MODE_ADD, KEY_ZERO, 1'b0);
    push_req(MODE_LOOKUP, KEY_MIN, 1'b0);
    push_req(MODE_SPARE, KEY_NEG1, 1'b0);
    push_req(MODE_SPARE, KEY_ONE, 1'b0);
    push_req(MODE_LOOKUP, 48'h800000000001, 1'b0);
    // Remove from the middle and check the shift
    push_req(MODE_REMOVE, KEY_MIN, 1'b0);
    push_req(MODE_LOOKUP, KEY_NEG1, 1'b0);
    push_req(MODE_REMOVE, KEY_MAX, 1'b0);
    push_req(MODE_ADD, KEY_ONE, 1'b0);
    push_req(MODE_REMOVE, KEY_ZERO, 1'b0);
    push_req(MODE_REMOVE, KEY_ZERO, 1'b0);
    push_req(MODE_LOOKUP, KEY_ONE, 1'b0);
    push_req(MODE_ADD, KEY_MIN, 1'b0);
    directed_n = pending_reqs.size();

    // Fill past capacity once with distinct random keys so the refused add
    // is always seen; drain the pipe first
    for (int i = 0; i < CAP + 8; i++) begin
      key_pool.push_back(KEY_W'({$urandom, $urandom}));
      push_req(MODE_ADD, key_pool[$], (i == 0));
    end

    while (pending_reqs.size() < directed_n + RANDOM_ITEMS) begin
      seg = $urandom_range(0, 9);
      if (seg <= 1) begin
        n = $urandom_range(8, CAP + 6);
        for (int i = 0; i < n; i++) begin
          key_pool.push_back(fresh_key());
          push_req(MODE_ADD, key_pool[$], 1'b0);
        end
      end else if (seg <= 3) begin
        n = $urandom_range(5, 40);
        for (int i = 0; i < n && key_pool.size() > 0; i++) begin
          idx = $urandom_range(0, key_pool.size() - 1);
          push_req(MODE_REMOVE, key_pool[idx], 1'b0);
          key_pool.delete(idx);
        end
      end else begin
        n = $urandom_range(10, 30);
        for (int i = 0; i < n; i++) begin
          if (key_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, key_pool.size() - 1);
            push_req(MODE_W'($urandom_range(0, 3)), key_pool[idx], 1'b0);
          end else begin
            key_pool.push_back(fresh_key());
            push_req(MODE_W'($urandom_range(0, 3)), key_pool[$], 1'b0);
          end
        end
      end
      while (key_pool.size() > 200) void'(key_pool.pop_front());
      // Pause the sender once more near the middle of the random part
      if (pending_reqs.size() >= 260 && pending_reqs.size() < 290)
        pending_reqs[$].quiet_first = 1'b1;
    end
    n_total = pending_reqs.size();
  end

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return KEY_ZERO;
      3: return KEY_NEG1;
      default: return raw[KEY_W-1:0];
    endcase
  endfunction

  function automatic void push_req(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k, bit q);
    request_t r;
    r.mode        = m;
    r.key         = k;
    r.quiet_first = q;
    pending_reqs.push_back(r);
  endfunction

  // Request driver: predict on acceptance, then offer the next request or idle
  int  in_gap = 0;
  bit  in_tail;
  bit  in_calm;
  bit  took;
  request_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_results.push_back(apply_request(mode, key));
        n_sent <= n_sent + 1;
      end
      // Hold the payload while the block stalls it
      if (!in_valid || !in_stall) begin
        in_tail = (n_total > 0) && (n_sent >= n_total - TAIL_ITEMS);
        in_calm = ((n_sent / 48) % 3) == 1;
        if (in_gap > 0 && !in_tail) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_reqs[0].quiet_first && (took || n_sent != n_seen)) begin
          // drain every outstanding result before this request goes out
          in_valid <= 1'b0;
        end else if (!in_tail && !in_calm && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 6) - 1;
          in_valid <= 1'b0;
        end else begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          mode     <= next_req.mode;
          key      <= next_req.key;
        end
      end
    end
  end

  // Output stall: random bursts, one long hold that backs up the block
  int  out_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (n_total > 0 && n_sent >= n_total - TAIL_ITEMS) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (((n_sent / 48) % 3) == 2) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_gap = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction
  set_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_seen <= n_seen + 1;
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual found=%0b pos=%0d count=%0d",
                 $time, found, position, entry_count);
      end else begin
        want = expected_results.pop_front();
        check_field("found", WIDE_W'(want.found), WIDE_W'(found));
        check_field("position", WIDE_W'(want.position), WIDE_W'(position));
        check_field("entry_count", WIDE_W'(want.entry_count), WIDE_W'(entry_count));
        check_field("total", {{(WIDE_W-TOTAL_W){1'b0}}, want.total},
                    {{(WIDE_W-TOTAL_W){1'b0}}, total});
        check_field("status", WIDE_W'(want.status), WIDE_W'(status));
      end
    end
  end

  // End of run: wait for every request and result, then let the pipe settle
  initial begin
    @(posedge clk);
    while (rst || n_total == 0 || n_sent < n_total) @(posedge clk);
    while (n_seen < n_sent) @(posedge clk);
    repeat (CAP + 10) @(posedge clk);
    if (expected_results.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    if (err_count == 0) begin
      $display("[unique_value_set_table] OK");
    end else begin
      $display("[unique_value_set_table] ERROR");
    end
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    #5_000_000;
    $display("[unique_value_set_table] ERROR");
    $finish;
  end

endmodule
